// ----- hw/rtl/qmr_pkg.sv -----
// Package: shared constants and types for the quaternion multiply/renormalize block.
`timescale 1ns / 1ps
package qmr_pkg;
  localparam int unsigned CompWidthDefault = 32;
  localparam int unsigned TolWidth = 31;
  localparam int unsigned TolFrac = 30;
  localparam logic [TolWidth-1:0] TolReset = 31'd107374;
  localparam logic [1:0] RegUnitTol = 2'd0;
endpackage

// ----- hw/rtl/quaternion_multiply_renormalise_top.sv -----
// Top level: pipelined Hamilton product with conditional renormalization.
`timescale 1ns / 1ps
// Usage:
//   Drive the eight components with start_i high; busy_o is always low,
//   so a word is taken in every cycle. Each result appears for one cycle
//   with done_o high, carrying out_*_o and the two flags.
//   The pipeline is fixed-length: multiply, accumulate, round, square, sum,
//   tolerance check, then an iterative square root (one result bit per
//   stage, W+4 stages) and a restoring divider per component (one quotient
//   bit per stage, 2*W+3 stages), then select and saturation.
//   W = COMPONENT_WIDTH. Throughput is one word per cycle, set by the fully
//   staged sqrt and divide chains.
//   unit_tolerance is written over the APB port at address 0; prdata
//   returns it. Reset clears all valid bits and restores the tolerance.
//   The receiver cannot stall; results are never held.
module quaternion_multiply_renormalise_top #(
  parameter int unsigned COMPONENT_WIDTH = qmr_pkg::CompWidthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  logic signed [COMPONENT_WIDTH-1:0] r_w_i, r_x_i, r_y_i, r_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0] s_w_i, s_x_i, s_y_i, s_z_i,
  output logic done_o,
  output logic signed [COMPONENT_WIDTH-1:0] out_w_o, out_x_o, out_y_o, out_z_o,
  output logic renormalised_o,
  output logic zero_magnitude_o,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import qmr_pkg::*;
  localparam int W = COMPONENT_WIDTH;
  localparam int F = W - 2;
  localparam int PW = 2 * W;           // product magnitude width
  localparam int AW = 2 * W + 3;       // signed accumulator
  localparam int MW = W + 3;           // rounded magnitude
  localparam int SW = 2 * MW + 2;      // squared sum
  localparam int RW = MW + 1;          // sqrt width (covers SW/2)
  localparam int NW = MW + F + 2;      // dividend width
  localparam int DW = RW + 1;          // divisor width
  localparam int QW = NW;              // quotient bits

  // ---------------- configuration ----------------
  logic [TolWidth-1:0] tol_q;
  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign prdata = (paddr[2] == RegUnitTol[0] && paddr[1:0] == 2'b00)
                  ? {1'b0, tol_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (psel && penable && pwrite && paddr[2] == RegUnitTol[0]) begin
      tol_q <= pwdata[TolWidth-1:0];
    end
  end

  // ---------------- stage 1: signed products ----------------
  logic signed [W-1:0] r_c [4];
  logic signed [W-1:0] s_c [4];
  assign r_c[0] = r_w_i; assign r_c[1] = r_x_i; assign r_c[2] = r_y_i; assign r_c[3] = r_z_i;
  assign s_c[0] = s_w_i; assign s_c[1] = s_x_i; assign s_c[2] = s_y_i; assign s_c[3] = s_z_i;
  localparam logic [1:0] TA [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2,
                                      2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
  localparam logic [1:0] TB [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
                                      2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3};
  localparam logic       TN [16] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
                                      1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

  logic v1_q;
  logic signed [PW:0] p_q [16];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    for (int t = 0; t < 16; t++) begin
      p_q[t] <= TN[t] ? -($signed({r_c[TA[t]][W-1], r_c[TA[t]]}) * s_c[TB[t]])
                      :  ($signed({r_c[TA[t]][W-1], r_c[TA[t]]}) * s_c[TB[t]]);
    end
  end

  // ---------------- stage 2: accumulate ----------------
  logic v2_q;
  logic signed [AW-1:0] acc_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      acc_q[c] <= AW'(p_q[4*c]) + AW'(p_q[4*c+1]) + AW'(p_q[4*c+2]) + AW'(p_q[4*c+3]);
    end
  end

  // ---------------- stage 3: round half away from zero ----------------
  logic v3_q;
  logic [MW-1:0] cm_q [4];
  logic          cn_q [4];
  logic [AW-1:0] amag [4];
  logic [AW-1:0] arnd [4];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      amag[c] = acc_q[c][AW-1] ? AW'(-acc_q[c]) : AW'(acc_q[c]);
      arnd[c] = amag[c] + (AW'(1) << (F - 1));
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      cm_q[c] <= arnd[c][F +: MW];
      cn_q[c] <= acc_q[c][AW-1];
    end
  end

  // ---------------- stage 4: squares ----------------
  logic v4_q;
  logic [2*MW-1:0] sq_q [4];
  logic [MW-1:0] cm4_q [4];
  logic          cn4_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      sq_q[c] <= cm_q[c] * cm_q[c];
      cm4_q[c] <= cm_q[c];
      cn4_q[c] <= cn_q[c];
    end
  end

  // ---------------- stage 5: sum, tolerance, zero check ----------------
  logic [SW-1:0] sum;
  logic [SW-1:0] one;
  logic [SW-1:0] diff;
  logic          pass;
  assign sum = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]) + SW'(sq_q[3]);
  assign one = SW'(1) << (2 * F);
  assign diff = (sum < one) ? one - sum : sum - one;
  // diff << TolFrac < tol << 2F, compared in a wide unsigned space
  assign pass = ({diff, TolFrac'(0)} < ({(SW + TolFrac - TolWidth)'(0), tol_q} << (2 * F)));

  localparam int NS = RW;        // sqrt stages
  localparam int ND = QW;        // divide stages
  localparam int L = NS + ND + 1;  // one extra stage loads the divider

  typedef struct packed {
    logic zero;
    logic pass;
    logic [3:0] neg;
  } ctl_t;

  logic [L:0] cv_q;
  ctl_t ctl_q [L+1];
  logic [SW-1:0] rad_q [NS+1];
  logic [RW-1:0] root_q [NS+1];
  logic [2*RW-1:0] rsq_q [NS+1];
  logic [MW-1:0] cms_q [NS+1][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else begin
      cv_q <= {cv_q[L-1:0], v4_q};
    end
  end
  always_ff @(posedge clk_i) begin
    ctl_q[0].zero <= (sum == '0);
    ctl_q[0].pass <= pass;
    ctl_q[0].neg <= {cn4_q[3], cn4_q[2], cn4_q[1], cn4_q[0]};
    for (int k = 1; k <= L; k++) begin
      ctl_q[k].zero <= ctl_q[k-1].zero;
      ctl_q[k].pass <= ctl_q[k-1].pass;
      ctl_q[k].neg <= ctl_q[k-1].neg;
    end
    rad_q[0] <= sum;
    root_q[0] <= '0;
    rsq_q[0] <= '0;
    for (int c = 0; c < 4; c++) cms_q[0][c] <= cm4_q[c];
  end

  // ---------------- sqrt: one result bit per stage ----------------
  // root^2 travels along, so the trial square needs only shifts and adds
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam int B = NS - 1 - k;
    logic [RW-1:0] cand;
    logic [2*RW-1:0] csq;
    assign cand = root_q[k] | (RW'(1) << B);
    // (root + 2^B)^2 = root^2 + root * 2^(B+1) + 2^(2B)
    assign csq = rsq_q[k] + ((2*RW)'(root_q[k]) << (B + 1)) + ((2*RW)'(1) << (2 * B));
    always_ff @(posedge clk_i) begin
      rad_q[k+1] <= rad_q[k];
      if ((2*RW)'(rad_q[k]) >= csq) begin
        root_q[k+1] <= cand;
        rsq_q[k+1] <= csq;
      end else begin
        root_q[k+1] <= root_q[k];
        rsq_q[k+1] <= rsq_q[k];
      end
      for (int c = 0; c < 4; c++) cms_q[k+1][c] <= cms_q[k][c];
    end
  end

  // ---------------- divide: one quotient bit per stage ----------------
  logic [NW-1:0] num_q [ND+1][4];
  logic [DW:0]   rem_q [ND+1][4];
  logic [QW-1:0] quo_q [ND+1][4];
  logic [DW-1:0] den_q [ND+1];
  logic [MW-1:0] cmd_q [ND+1][4];
  always_ff @(posedge clk_i) begin
    den_q[0] <= {root_q[NS], 1'b0};
    for (int c = 0; c < 4; c++) begin
      num_q[0][c] <= (NW'(cms_q[NS][c]) << (F + 1)) + NW'(root_q[NS]);
      rem_q[0][c] <= '0;
      quo_q[0][c] <= '0;
      cmd_q[0][c] <= cms_q[NS][c];
    end
  end
  for (genvar k = 0; k < ND; k++) begin : g_div
    localparam int B = ND - 1 - k;
    logic [DW:0] sh [4];
    always_comb begin
      for (int c = 0; c < 4; c++) sh[c] = {rem_q[k][c][DW-1:0], num_q[k][c][B]};
    end
    always_ff @(posedge clk_i) begin
      den_q[k+1] <= den_q[k];
      for (int c = 0; c < 4; c++) begin
        num_q[k+1][c] <= num_q[k][c];
        cmd_q[k+1][c] <= cmd_q[k][c];
        if (sh[c] >= (DW+1)'(den_q[k])) begin
          rem_q[k+1][c] <= sh[c] - (DW+1)'(den_q[k]);
          quo_q[k+1][c] <= quo_q[k][c] | (QW'(1) << B);
        end else begin
          rem_q[k+1][c] <= sh[c];
          quo_q[k+1][c] <= quo_q[k][c];
        end
      end
    end
  end

  // ---------------- output: select and saturate ----------------
  ctl_t ce;
  assign ce = ctl_q[L];
  logic [QW-1:0] mag [4];
  logic [W-1:0]  res [4];
  localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mag[c] = ce.pass ? QW'(cmd_q[ND][c]) : quo_q[ND][c];
      if (ce.neg[c]) begin
        res[c] = (mag[c] > QW'(MaxPos) + QW'(1)) ? ~MaxPos : W'(-mag[c]);
      end else begin
        res[c] = (mag[c] > QW'(MaxPos)) ? MaxPos : mag[c][W-1:0];
      end
      if (ce.zero) res[c] = '0;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= cv_q[L];
  end
  always_ff @(posedge clk_i) begin
    out_w_o <= res[0]; out_x_o <= res[1]; out_y_o <= res[2]; out_z_o <= res[3];
    renormalised_o <= !ce.zero && !ce.pass;
    zero_magnitude_o <= ce.zero;
  end

  // ---------------- assertions ----------------
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(renormalised_o && zero_magnitude_o)) else $error("both flags set");
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_magnitude_o) |-> (out_w_o == '0 && out_x_o == '0 &&
     out_y_o == '0 && out_z_o == '0)) else $error("zero magnitude with nonzero output");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |=> cv_q[0]) else $error("valid lost in pipeline");
endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench: random and directed quaternion products checked against a local predictor.
`timescale 1ns / 1ps
module tb_top;
  import qmr_pkg::*;

  localparam int unsigned CW = 32;
  // pipeline depth of the block, used as a drain allowance
  localparam int unsigned PipeLat = 3 * CW + 13;
  localparam logic [2:0] UnitTolAddr = 3'(4 * RegUnitTol);
  localparam logic [CW-1:0] QOne = 32'sh4000_0000;  // 1.0 in Q1.30
  localparam logic [CW-1:0] QHalf = 32'sh2000_0000;
  localparam logic [CW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic [CW-1:0] QMin = 32'sh8000_0000;

  // one input word: index 0..3 = w, x, y, z
  typedef struct packed {
    logic [3:0][CW-1:0] r;
    logic [3:0][CW-1:0] s;
  } quat_pair_t;

  typedef struct packed {
    logic [3:0][CW-1:0] c;
    logic               renorm;
    logic               zero;
  } qprod_t;

  typedef enum int {GenFull, GenScaled, GenNearUnit} gen_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [CW-1:0] r_w_i = '0, r_x_i = '0, r_y_i = '0, r_z_i = '0;
  logic signed [CW-1:0] s_w_i = '0, s_x_i = '0, s_y_i = '0, s_z_i = '0;
  logic done_o;
  logic signed [CW-1:0] out_w_o, out_x_o, out_y_o, out_z_o;
  logic renormalised_o, zero_magnitude_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  quaternion_multiply_renormalise_top #(.COMPONENT_WIDTH(CW)) u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .r_w_i, .r_x_i, .r_y_i, .r_z_i, .s_w_i, .s_x_i, .s_y_i, .s_z_i,
    .done_o, .out_w_o, .out_x_o, .out_y_o, .out_z_o,
    .renormalised_o, .zero_magnitude_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  quat_pair_t pend_q[$];  // words waiting for the driver
  qprod_t prod_q[$];      // predicted products, oldest first
  quat_pair_t on_bus;     // word currently on the input ports
  logic [TolWidth-1:0] tol_shadow = TolReset;
  logic hold = 1'b0;      // sender pause, set by the sequencer
  int burst_left = 0, gap_left = 0;
  int err_cnt = 0, n_pass = 0, n_renorm = 0, n_zero = 0;

  // run limit: ~1000 words with worst gaps plus pipeline drains, many times over
  initial begin
    #4_000_000;
    $display("timeout: %0d results still owed", prod_q.size());
    $display("[quaternion_multiply_renormalise_top] ERROR");
    $finish;
  end

  task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  // saturate a magnitude into the signed Q1.30 range
  function automatic logic [CW-1:0] clamp_q130(logic neg, logic [127:0] m);
    logic [127:0] lim;
    logic [127:0] v;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    v = (m > lim) ? lim : m;
    return neg ? -v[CW-1:0] : v[CW-1:0];
  endfunction

  // Hamilton product, round half away from zero, then conditional renormalize
  function automatic qprod_t hamilton_predict(quat_pair_t q, logic [TolWidth-1:0] tol);
    logic signed [127:0] a[4], b[4], acc[4];
    logic [127:0] mag, sum, diff, root, cand, num;
    logic [127:0] cm[4];
    logic cneg[4];
    qprod_t o;
    for (int i = 0; i < 4; i++) begin
      a[i] = {{(128-CW){q.r[i][CW-1]}}, q.r[i]};
      b[i] = {{(128-CW){q.s[i][CW-1]}}, q.s[i]};
    end
    acc[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
    acc[1] = a[1]*b[0] + a[0]*b[1] - a[3]*b[2] + a[2]*b[3];
    acc[2] = a[2]*b[0] + a[3]*b[1] + a[0]*b[2] - a[1]*b[3];
    acc[3] = a[3]*b[0] - a[2]*b[1] + a[1]*b[2] + a[0]*b[3];
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      cneg[i] = acc[i][127];
      mag = cneg[i] ? -acc[i] : acc[i];
      mag = mag + (128'd1 << (CW - 3));
      cm[i] = mag >> (CW - 2);
      sum = sum + cm[i] * cm[i];
    end
    o = '0;
    if (sum == '0) begin
      o.zero = 1'b1;
      return o;
    end
    diff = (sum >= (128'd1 << 60)) ? sum - (128'd1 << 60) : (128'd1 << 60) - sum;
    if ((diff << TolFrac) < ({97'd0, tol} << 60)) begin
      for (int i = 0; i < 4; i++) o.c[i] = clamp_q130(cneg[i], cm[i]);
      return o;
    end
    root = '0;
    for (int k = 63; k >= 0; k--) begin
      cand = root | (128'd1 << k);
      if (cand * cand <= sum) root = cand;
    end
    for (int i = 0; i < 4; i++) begin
      num = (cm[i] << (CW - 1)) + root;
      o.c[i] = clamp_q130(cneg[i], num / (root << 1));
    end
    o.renorm = 1'b1;
    return o;
  endfunction

  // driver: bursts of random length, random gaps, holds while paused
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!(start_i && busy_o)) begin
      if (start_i) prod_q.push_back(hamilton_predict(on_bus, tol_shadow));
      if (gap_left > 0) begin
        gap_left--;
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap_left == 0 && burst_left > 0 && !hold && pend_q.size() > 0) begin
        on_bus = pend_q.pop_front();
        {r_w_i, r_x_i, r_y_i, r_z_i} <= {on_bus.r[0], on_bus.r[1], on_bus.r[2], on_bus.r[3]};
        {s_w_i, s_x_i, s_y_i, s_z_i} <= {on_bus.s[0], on_bus.s[1], on_bus.s[2], on_bus.s[3]};
        start_i <= 1'b1;
        burst_left--;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: every strobed word must match the oldest prediction
  always @(posedge clk_i) begin
    qprod_t want;
    if (rst_ni && done_o) begin
      if (prod_q.size() == 0) begin
        report_mismatch("unexpected result word, out_w", out_w_o, '0);
      end else begin
        want = prod_q.pop_front();
        if (out_w_o !== want.c[0]) report_mismatch("out_w", out_w_o, want.c[0]);
        if (out_x_o !== want.c[1]) report_mismatch("out_x", out_x_o, want.c[1]);
        if (out_y_o !== want.c[2]) report_mismatch("out_y", out_y_o, want.c[2]);
        if (out_z_o !== want.c[3]) report_mismatch("out_z", out_z_o, want.c[3]);
        if (renormalised_o !== want.renorm)
          report_mismatch("renormalised", CW'(renormalised_o), CW'(want.renorm));
        if (zero_magnitude_o !== want.zero)
          report_mismatch("zero_magnitude", CW'(zero_magnitude_o), CW'(want.zero));
        if (want.zero) n_zero++;
        else if (want.renorm) n_renorm++;
        else n_pass++;
      end
    end
  end

  function automatic quat_pair_t make_pair(logic [CW-1:0] rw, rx, ry, rz, sw, sx, sy, sz);
    quat_pair_t p;
    p.r = {rz, ry, rx, rw};
    p.s = {sz, sy, sx, sw};
    return p;
  endfunction

  function automatic logic [CW-1:0] rand_comp(gen_mode_e mode);
    logic signed [CW-1:0] v;
    v = $urandom;
    if (mode == GenScaled) v = v >>> $urandom_range(0, 31);
    if (mode == GenNearUnit) v = v >>> $urandom_range(8, 31);
    return v;
  endfunction

  // near-unit: one axis at +-1.0, small noise elsewhere
  function automatic quat_pair_t rand_pair(gen_mode_e mode);
    quat_pair_t p;
    for (int i = 0; i < 4; i++) begin
      p.r[i] = rand_comp(mode);
      p.s[i] = rand_comp(mode);
    end
    if (mode == GenNearUnit) begin
      p.r[$urandom_range(0, 3)] += $urandom_range(0, 1) ? -QOne : QOne;
      p.s[$urandom_range(0, 3)] += $urandom_range(0, 1) ? -QOne : QOne;
    end
    return p;
  endfunction

  task automatic apb_xfer(logic wr, logic [31:0] wdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= UnitTolAddr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (!wr && prdata[TolWidth-1:0] !== tol_shadow)
      report_mismatch("unit_tolerance readback", prdata, 32'(tol_shadow));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_tolerance(logic [TolWidth-1:0] tol);
    apb_xfer(1'b1, 32'(tol));
    tol_shadow = tol;
    apb_xfer(1'b0, '0);
  endtask

  // pause the sender until the pipeline has drained
  task automatic drain;
    wait (pend_q.size() == 0 && !start_i);
    hold = 1'b1;
    wait (prod_q.size() == 0);
    repeat (PipeLat + 8) @(posedge clk_i);
    hold = 1'b0;
  endtask

  task automatic queue_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      pend_q.push_back(rand_pair(pick < 4 ? GenNearUnit : pick < 7 ? GenScaled : GenFull));
    end
  endtask

  initial begin
    logic [TolWidth-1:0] tol_set[5];
    tol_set = '{TolReset, 31'd0, 31'h4000_0000, 31'($urandom_range(1, 1 << 24)), TolReset};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_xfer(1'b0, '0);  // reset value of the tolerance
    // directed words
    pend_q.push_back(make_pair('0, '0, '0, '0, '0, '0, '0, '0));
    pend_q.push_back(make_pair(QOne, '0, '0, '0, QOne, '0, '0, '0));
    pend_q.push_back(make_pair(QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax));
    pend_q.push_back(make_pair(QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin));
    pend_q.push_back(make_pair(QMax, QMin, QMax, QMin, QMin, QMax, QMin, QMax));
    pend_q.push_back(make_pair(QMin, '0, '0, '0, QMin, '0, '0, '0));
    pend_q.push_back(make_pair('0, QOne, '0, '0, '0, '0, QOne, '0));   // i*j = k
    pend_q.push_back(make_pair('0, '0, QOne, '0, '0, '0, '0, QOne));   // j*k = i
    pend_q.push_back(make_pair('0, '0, '0, QOne, '0, QOne, '0, '0));   // k*i = j
    pend_q.push_back(make_pair(1, 1, 1, 1, 1, 1, 1, 1));               // rounds to zero
    pend_q.push_back(make_pair(QHalf, QHalf, QHalf, QHalf, QHalf, QHalf, QHalf, QHalf));
    pend_q.push_back(make_pair(QHalf, '0, '0, '0, QOne, '0, '0, '0));  // renormalize 0.5
    pend_q.push_back(make_pair(-QOne, '0, '0, '0, QOne, '0, '0, '0));
    pend_q.push_back(make_pair(32'sh8000, '0, '0, '0, 32'sh4000, '0, '0, '0));  // round half up
    pend_q.push_back(make_pair(-32'sh8000, '0, '0, '0, 32'sh4000, '0, '0, '0));
    pend_q.push_back(make_pair(QOne + 32'sd2000, '0, '0, '0, QOne, '0, '0, '0)); // in tolerance
    pend_q.push_back(make_pair(QOne + 32'sh10_0000, '0, '0, '0, QOne, '0, '0, '0));
    pend_q.push_back(make_pair(QMax, '0, '0, '0, QMax, '0, '0, '0));
    queue_random(120);
    drain();
    // remaining phases each under a new tolerance, the extremes among them
    for (int ph = 1; ph < 5; ph++) begin
      set_tolerance(tol_set[ph]);
      queue_random(170);
      drain();
    end
    repeat (PipeLat + 10) @(posedge clk_i);
    if (prod_q.size() != 0) begin
      report_mismatch("predicted results never arrived", CW'(prod_q.size()), '0);
    end
    $display("covered: %0d pass-through, %0d renormalized, %0d zero-magnitude words",
             n_pass, n_renorm, n_zero);
    $display("tolerances used: reset, zero, one, random; %0d mismatches", err_cnt);
    if (err_cnt == 0) begin
      $display("[quaternion_multiply_renormalise_top] OK");
    end else begin
      $display("[quaternion_multiply_renormalise_top] ERROR");
    end
    $finish;
  end
endmodule
